// File: hdl/code_signature_hook_scanner_top_macros.svh
// Assertion macros used by the checker file of the hook scanner.
`ifndef CODE_SIGNATURE_HOOK_SCANNER_TOP_MACROS_SVH
`define CODE_SIGNATURE_HOOK_SCANNER_TOP_MACROS_SVH

// Check a property at every clock edge outside reset.
`define CHSS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every clock edge, reset included.
`define CHSS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hdl/chss_pkg.sv
// Package: shared types and constants of the code signature hook scanner.
`default_nettype none

package chss_pkg;

    // Data and configuration widths
    localparam int WORD_W    = 32;
    localparam int MAXD_W    = 25;
    localparam int PADDR_W   = 5;
    localparam int SIG_REGS  = 4;
    localparam int SIG_IDX_W = 2;

    // Configuration register map, one word apart
    typedef enum logic [2:0] {
        REG_SIG0 = 3'd0,
        REG_SIG1 = 3'd1,
        REG_SIG2 = 3'd2,
        REG_SIG3 = 3'd3,
        REG_TERM = 3'd4,
        REG_MAXD = 3'd5
    } chss_reg_idx_t;

    // Reset values of the configuration registers
    localparam logic [WORD_W-1:0] SIG_RESET [SIG_REGS] = '{
        32'h7CE3_3B78, 32'h3887_0034, 32'h38A7_0038, 32'h38C7_004C
    };
    localparam logic [WORD_W-1:0] TERM_RESET = 32'h4E80_0020;
    localparam logic [MAXD_W-1:0] MAXD_RESET = 25'h000_1000;

    // Control handed to every history cell
    typedef struct packed {
        logic shift;
        logic clear;
    } chss_cell_ctrl_t;

    // One result item
    typedef struct packed {
        logic              hook_found;
        logic [WORD_W-1:0] hook_address;
    } chss_result_t;

endpackage

`default_nettype wire

// File: hdl/chss_in_if.sv
// Interface: input channel carrying one code word item.
`default_nettype none

interface chss_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] code_word;
    logic [31:0] word_address;
    logic        range_start;
    logic        new_scan;

    modport source (
        output valid, code_word, word_address, range_start, new_scan,
        input  ready
    );
    modport sink (
        input  valid, code_word, word_address, range_start, new_scan,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/chss_out_if.sv
// Interface: output channel carrying one scan result item.
`default_nettype none

interface chss_out_if;
    logic        valid;
    logic        ready;
    logic        hook_found;
    logic [31:0] hook_address;

    modport source (
        output valid, hook_found, hook_address,
        input  ready
    );
    modport sink (
        input  valid, hook_found, hook_address,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/chss_cell.sv
// History cell: holds one past code word, compares it and hands it on.
`default_nettype none

module chss_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire chss_pkg::chss_cell_ctrl_t     ctrl,
    input  wire logic [chss_pkg::WORD_W-1:0]   word_in,
    input  wire logic                          valid_in,
    input  wire logic [chss_pkg::WORD_W-1:0]   sig_word,
    output logic      [chss_pkg::WORD_W-1:0]   word_out,
    output logic                               valid_out,
    output logic                               hit
);

    logic [chss_pkg::WORD_W-1:0] word_reg;
    logic [chss_pkg::WORD_W-1:0] word_next;
    logic                        valid_reg;
    logic                        valid_next;

    // Take the neighbor's word on every accepted item, drop validity on clear
    always_comb
    begin
        word_next  = ctrl.shift ? word_in : word_reg;
        valid_next = valid_reg;
        if (ctrl.shift)
        begin
            valid_next = valid_in & ~ctrl.clear;
        end
    end

    // Hold validity
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the stored word
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    // Compare against this cell's signature word
    assign hit       = valid_reg && (word_reg == sig_word);
    assign word_out  = word_reg;
    assign valid_out = valid_reg;

endmodule

`default_nettype wire

// File: hdl/chss_out_buf.sv
// Output stage: result register plus skid register between the two channels.
`default_nettype none

module chss_out_buf (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push_valid,
    output logic                        push_ready,
    input  wire chss_pkg::chss_result_t push_data,
    chss_out_if.source                  out_ch
);

    logic                   out_valid_reg;
    logic                   out_valid_next;
    chss_pkg::chss_result_t out_data_reg;
    chss_pkg::chss_result_t out_data_next;
    logic                   skid_valid_reg;
    logic                   skid_valid_next;
    chss_pkg::chss_result_t skid_data_reg;
    chss_pkg::chss_result_t skid_data_next;
    logic                   push;
    logic                   pop;

    assign push_ready = ~skid_valid_reg;
    assign push       = push_valid && push_ready;
    assign pop        = out_valid_reg && out_ch.ready;

    // Advance the two stages
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold stage occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Hold stage payloads
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.hook_found   = out_data_reg.hook_found;
    assign out_ch.hook_address = out_data_reg.hook_address;

endmodule

`default_nettype wire

// File: hdl/code_signature_hook_scanner_top.sv
// Top level: signature hook scanner with history cell chain and APB registers.
`default_nettype none

// Takes one code word item per clock while input ready is high and returns one
// result item per word, registered in the output or skid register. Input ready
// stays high unless both the output register and the skid register hold
// results, so a stream runs at one item per cycle while the sink keeps up. The
// rate is set by one pass through the history cell chain (one 32-bit compare
// per cell, the last signature word compared against the incoming word)
// together with one 32-bit subtract and compare for the terminator distance.
// There are SIGNATURE_WORDS-1 history cells. Registers are written and read
// over APB at byte address 4*index; write them only while no item is in flight.
module code_signature_hook_scanner_top #(
    parameter int SIGNATURE_WORDS = 4
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    chss_in_if.sink                             in_ch,
    chss_out_if.source                          out_ch,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [chss_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [31:0]                    pwdata,
    output logic      [31:0]                    prdata,
    output logic                                pready
);

    localparam int                          DEPTH      = SIGNATURE_WORDS - 1;
    localparam logic [chss_pkg::WORD_W-1:0] START_BACK = chss_pkg::WORD_W'(4 * DEPTH);

    // Configuration registers
    logic [chss_pkg::WORD_W-1:0] sig_reg [chss_pkg::SIG_REGS];
    logic [chss_pkg::WORD_W-1:0] term_reg;
    logic [chss_pkg::MAXD_W-1:0] maxd_reg;
    logic                        cfg_wr;
    chss_pkg::chss_reg_idx_t     cfg_idx;

    // Scan state
    logic                        pend_valid_reg;
    logic                        pend_valid_next;
    logic [chss_pkg::WORD_W-1:0] pend_start_reg;
    logic [chss_pkg::WORD_W-1:0] pend_start_next;
    logic                        found_reg;
    logic                        found_next;
    logic [chss_pkg::WORD_W-1:0] found_addr_reg;
    logic [chss_pkg::WORD_W-1:0] found_addr_next;

    logic                        in_accept;
    logic                        push_ready;
    logic                        clr_hist;
    logic                        hist_ok;
    logic [chss_pkg::WORD_W-1:0] sig_last;
    logic [chss_pkg::WORD_W-1:0] term_dist;
    logic                        term_hit;
    logic                        sig_match;
    logic                        found_pre;
    logic [chss_pkg::WORD_W-1:0] found_addr_pre;
    logic                        pend_valid_pre;
    logic [chss_pkg::WORD_W-1:0] pend_start_pre;
    chss_pkg::chss_result_t      result;

    assign in_accept   = in_ch.valid && push_ready;
    assign in_ch.ready = push_ready;
    assign clr_hist    = in_ch.range_start || in_ch.new_scan;

    // APB write decode
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = chss_pkg::chss_reg_idx_t'(paddr[4:2]);

    // Hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < chss_pkg::SIG_REGS; i++)
            begin
                sig_reg[i] <= chss_pkg::SIG_RESET[i];
            end
            term_reg <= chss_pkg::TERM_RESET;
            maxd_reg <= chss_pkg::MAXD_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                chss_pkg::REG_SIG0: sig_reg[0] <= pwdata;
                chss_pkg::REG_SIG1: sig_reg[1] <= pwdata;
                chss_pkg::REG_SIG2: sig_reg[2] <= pwdata;
                chss_pkg::REG_SIG3: sig_reg[3] <= pwdata;
                chss_pkg::REG_TERM: term_reg   <= pwdata;
                chss_pkg::REG_MAXD: maxd_reg   <= pwdata[chss_pkg::MAXD_W-1:0];
                default:            ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (cfg_idx)
            chss_pkg::REG_SIG0: prdata = sig_reg[0];
            chss_pkg::REG_SIG1: prdata = sig_reg[1];
            chss_pkg::REG_SIG2: prdata = sig_reg[2];
            chss_pkg::REG_SIG3: prdata = sig_reg[3];
            chss_pkg::REG_TERM: prdata = term_reg;
            chss_pkg::REG_MAXD: prdata = 32'(maxd_reg);
            default:            prdata = '0;
        endcase
    end

    // Pick the signature word that the incoming word must match
    generate
        if (DEPTH < chss_pkg::SIG_REGS)
        begin : g_last_reg
            assign sig_last = sig_reg[DEPTH];
        end
        else
        begin : g_last_zero
            assign sig_last = '0;
        end
    endgenerate

    // Build the history cell chain, oldest word in cell 0
    generate
        if (DEPTH > 0)
        begin : g_hist
            logic [chss_pkg::WORD_W-1:0] cell_word [DEPTH];
            logic [DEPTH-1:0]            cell_valid;
            logic [DEPTH-1:0]            cell_hit;

            for (genvar i = 0; i < DEPTH; i++)
            begin : g_cell
                chss_pkg::chss_cell_ctrl_t   ctrl;
                logic [chss_pkg::WORD_W-1:0] word_in;
                logic                        valid_in;
                logic [chss_pkg::WORD_W-1:0] sig_word;

                assign ctrl.shift = in_accept;
                if (i == DEPTH - 1)
                begin : g_tail
                    // Newest cell always takes the incoming word as valid
                    assign ctrl.clear = 1'b0;
                    assign word_in    = in_ch.code_word;
                    assign valid_in   = 1'b1;
                end
                else
                begin : g_body
                    assign ctrl.clear = clr_hist;
                    assign word_in    = cell_word[i+1];
                    assign valid_in   = cell_valid[i+1];
                end
                if (i < chss_pkg::SIG_REGS)
                begin : g_sig_reg
                    assign sig_word = sig_reg[i];
                end
                else
                begin : g_sig_zero
                    assign sig_word = '0;
                end

                chss_cell u_cell (
                    .clk       (clk),
                    .rst_n     (rst_n),
                    .ctrl      (ctrl),
                    .word_in   (word_in),
                    .valid_in  (valid_in),
                    .sig_word  (sig_word),
                    .word_out  (cell_word[i]),
                    .valid_out (cell_valid[i]),
                    .hit       (cell_hit[i])
                );
            end

            // Full history matches unless this item clears it
            assign hist_ok = (&cell_hit) && !clr_hist;
        end
        else
        begin : g_no_hist
            assign hist_ok = 1'b1;
        end
    endgenerate

    // Apply the clear flags before testing the word
    always_comb
    begin
        found_pre      = found_reg && !in_ch.new_scan;
        found_addr_pre = in_ch.new_scan ? '0 : found_addr_reg;
        pend_valid_pre = pend_valid_reg && !clr_hist;
        pend_start_pre = clr_hist ? '0 : pend_start_reg;
    end

    // Test as terminator of the pending signature, then as end of a new one
    assign term_dist = in_ch.word_address - pend_start_pre;
    assign term_hit  = !found_pre && pend_valid_pre && (in_ch.code_word == term_reg)
                       && (term_dist < 32'(maxd_reg));
    assign sig_match = hist_ok && (in_ch.code_word == sig_last);

    always_comb
    begin
        found_next      = found_pre || term_hit;
        found_addr_next = term_hit ? in_ch.word_address : found_addr_pre;
        pend_valid_next = pend_valid_pre || sig_match;
        pend_start_next = sig_match ? (in_ch.word_address - START_BACK) : pend_start_pre;
    end

    // Hold the scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_start_reg <= '0;
            found_reg      <= 1'b0;
            found_addr_reg <= '0;
        end
        else if (in_accept)
        begin
            pend_valid_reg <= pend_valid_next;
            pend_start_reg <= pend_start_next;
            found_reg      <= found_next;
            found_addr_reg <= found_addr_next;
        end
    end

    // Hand the result item to the output stage
    assign result.hook_found   = found_next;
    assign result.hook_address = found_addr_next;

    chss_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_ch.valid),
        .push_ready (push_ready),
        .push_data  (result),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire

// File: hdl/chss_checker.sv
// Checker: port-level assertions for the hook scanner, bound to the top level.
`default_nettype none

`include "code_signature_hook_scanner_top_macros.svh"

module chss_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        hook_found,
    input wire logic [31:0] hook_address,
    input wire logic        pready
);

    // An address is only reported with the found flag
    `CHSS_ASSERT(a_addr_needs_found, (out_valid && !hook_found) |-> (hook_address == 32'd0), "hook_address nonzero without hook_found")

    // Input stalls only while a result waits at the output
    `CHSS_ASSERT(a_stall_needs_result, !in_ready |-> out_valid, "input stalled with empty output")

    // A result appears only after an item was taken
    `CHSS_ASSERT(a_result_needs_item, $rose(out_valid) |-> $past(in_valid && in_ready), "result without accepted item")

    // A stalled result stays put
    `CHSS_ASSERT(a_result_holds, (out_valid && !out_ready) |=> (out_valid && $stable(hook_found) && $stable(hook_address)), "stalled result changed")

    // The register port never waits
    `CHSS_ASSERT_ALWAYS(a_pready_high, pready, "pready low")

endmodule

bind code_signature_hook_scanner_top chss_checker u_chss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .hook_found   (out_ch.hook_found),
    .hook_address (out_ch.hook_address),
    .pready       (pready)
);

`default_nettype wire
